// ----- hw/rtl/bbm_pkg.sv -----
package bbm_pkg;

    localparam int COORD_BITS = 12;
    localparam int EDGE_BITS  = COORD_BITS + 1;

    // A stored rectangle keeps its far edges instead of its extent, so the
    // overlap test and the union need only compares.
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [EDGE_BITS-1:0]  x1;
        logic [EDGE_BITS-1:0]  y1;
    } box_t;

    typedef enum logic [1:0] {
        WR_INPUT,
        WR_CUR,
        WR_KILL
    } wr_sel_t;

    typedef struct packed {
        logic    rd_en;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    load_cur;
        logic    fold;
        logic    out_load;
        logic    out_last;
        logic    out_empty;
        logic    out_overflow;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_live;
        logic touch;
        logic out_free;
    } dp_status_t;

    function automatic logic box_live(input box_t b);
        return (b.x1 != {1'b0, b.x}) && (b.y1 != {1'b0, b.y});
    endfunction

    function automatic logic box_touch(input box_t a, input box_t b);
        return ({1'b0, a.y} <= b.y1) && ({1'b0, b.y} <= a.y1) &&
               ({1'b0, a.x} <= b.x1) && ({1'b0, b.x} <= a.x1);
    endfunction

    function automatic box_t box_union(input box_t a, input box_t b);
        box_t r;
        r.x  = (a.x < b.x) ? a.x : b.x;
        r.y  = (a.y < b.y) ? a.y : b.y;
        r.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
        r.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
        return r;
    endfunction

endpackage

// ----- hw/rtl/bbm_if.sv -----
interface bbm_rect_if;
    logic        valid;
    logic        ready;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
    logic        frame_last;

    modport source (
        output valid, rect_x, rect_y, rect_width, rect_height, frame_last,
        input  ready
    );
    modport sink (
        input  valid, rect_x, rect_y, rect_width, rect_height, frame_last,
        output ready
    );
endinterface

interface bbm_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [12:0] out_width;
    logic [12:0] out_height;
    logic        out_last;
    logic        out_empty;
    logic        out_overflow;

    modport source (
        output valid, out_x, out_y, out_width, out_height, out_last, out_empty,
               out_overflow,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_width, out_height, out_last, out_empty,
               out_overflow,
        output ready
    );
endinterface

// ----- hw/rtl/bbm_ram.sv -----
module bbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bbm_datapath.sv -----
module bbm_datapath
    import bbm_pkg::*;
#(
    parameter int MAX_RECTS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  logic [$clog2(MAX_RECTS)-1:0] rd_addr,
    input  logic [$clog2(MAX_RECTS)-1:0] wr_addr,
    output dp_status_t                   status,
    input  logic [COORD_BITS-1:0]        in_x,
    input  logic [COORD_BITS-1:0]        in_y,
    input  logic [COORD_BITS-1:0]        in_width,
    input  logic [COORD_BITS-1:0]        in_height,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [COORD_BITS-1:0]        out_x,
    output logic [COORD_BITS-1:0]        out_y,
    output logic [EDGE_BITS-1:0]         out_width,
    output logic [EDGE_BITS-1:0]         out_height,
    output logic                         out_last,
    output logic                         out_empty,
    output logic                         out_overflow
);

    localparam int BOX_BITS = $bits(box_t);

    box_t                  rd_box;
    box_t                  wr_box;
    logic [BOX_BITS-1:0]   rd_word;
    box_t                  cur_reg, cur_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic [EDGE_BITS-1:0]  out_width_reg, out_width_next;
    logic [EDGE_BITS-1:0]  out_height_reg, out_height_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_empty_reg, out_empty_next;
    logic                  out_overflow_reg, out_overflow_next;

    bbm_ram #(
        .WIDTH (BOX_BITS),
        .DEPTH (MAX_RECTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_box),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_box = box_t'(rd_word);

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_INPUT:
            begin
                wr_box.x  = in_x;
                wr_box.y  = in_y;
                wr_box.x1 = {1'b0, in_x} + {1'b0, in_width};
                wr_box.y1 = {1'b0, in_y} + {1'b0, in_height};
            end
            WR_CUR:  wr_box = cur_reg;
            default: wr_box = '0;
        endcase
    end

    assign status.rd_live  = box_live(rd_box);
    assign status.touch    = box_touch(cur_reg, rd_box);
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.load_cur)
        begin
            cur_next = rd_box;
        end
        else if (cmd.fold)
        begin
            cur_next = box_union(cur_reg, rd_box);
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_x_next        = out_x_reg;
        out_y_next        = out_y_reg;
        out_width_next    = out_width_reg;
        out_height_next   = out_height_reg;
        out_last_next     = out_last_reg;
        out_empty_next    = out_empty_reg;
        out_overflow_next = out_overflow_reg;
        if (cmd.out_load)
        begin
            out_valid_next    = 1'b1;
            out_last_next     = cmd.out_last;
            out_empty_next    = cmd.out_empty;
            out_overflow_next = cmd.out_overflow;
            if (cmd.out_empty)
            begin
                out_x_next      = '0;
                out_y_next      = '0;
                out_width_next  = '0;
                out_height_next = '0;
            end
            else
            begin
                out_x_next      = rd_box.x;
                out_y_next      = rd_box.y;
                out_width_next  = rd_box.x1 - {1'b0, rd_box.x};
                out_height_next = rd_box.y1 - {1'b0, rd_box.y};
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg          <= cur_next;
        out_x_reg        <= out_x_next;
        out_y_reg        <= out_y_next;
        out_width_reg    <= out_width_next;
        out_height_reg   <= out_height_next;
        out_last_reg     <= out_last_next;
        out_empty_reg    <= out_empty_next;
        out_overflow_reg <= out_overflow_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_width    = out_width_reg;
    assign out_height   = out_height_reg;
    assign out_last     = out_last_reg;
    assign out_empty    = out_empty_reg;
    assign out_overflow = out_overflow_reg;

    // A word is only loaded when the output register is free or draining.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a word that was not taken");

    // Folding only ever grows the rectangle under test.
    a_fold_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold && !cmd.load_cur |=> (cur_reg.x <= $past(cur_reg.x)) &&
                                      (cur_reg.x1 >= $past(cur_reg.x1)))
        else $error("union shrank the rectangle");

endmodule

// ----- hw/rtl/bbm_controller.sv -----
module bbm_controller
    import bbm_pkg::*;
#(
    parameter int MAX_RECTS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_last,
    output logic                         in_ready,
    output dp_cmd_t                      cmd,
    output logic [$clog2(MAX_RECTS)-1:0] rd_addr,
    output logic [$clog2(MAX_RECTS)-1:0] wr_addr,
    input  dp_status_t                   status
);

    localparam int AW = $clog2(MAX_RECTS);
    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_RECTS);
    localparam logic [CW-1:0] ONE       = CW'(1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ_I,
        S_TAKE_I,
        S_SCAN_J,
        S_WRITE_I,
        S_EMIT_START,
        S_EMIT,
        S_EMPTY
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          overflow_reg, overflow_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [AW-1:0] last_reg, last_next;
    logic          any_live_reg, any_live_next;
    logic [CW-1:0] i_inc;
    logic [CW-1:0] j_inc;

    assign i_inc = i_reg + ONE;
    assign j_inc = j_reg + ONE;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        last_next     = last_reg;
        any_live_next = any_live_reg;
        cmd           = '0;
        cmd.wr_sel    = WR_INPUT;
        cmd.out_overflow = overflow_reg;
        rd_addr       = i_reg[AW-1:0];
        wr_addr       = i_reg[AW-1:0];
        in_ready      = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < MAX_COUNT)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_INPUT;
                        wr_addr    = count_reg[AW-1:0];
                        count_next = count_reg + ONE;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        i_next        = '0;
                        any_live_next = 1'b0;
                        state_next    = S_READ_I;
                    end
                end
            end
            S_READ_I:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = i_reg[AW-1:0];
                state_next = S_TAKE_I;
            end
            S_TAKE_I:
            begin
                cmd.load_cur = 1'b1;
                if (!status.rd_live || i_inc == count_reg)
                begin
                    // A live entry with nothing after it needs no write-back.
                    if (status.rd_live)
                    begin
                        any_live_next = 1'b1;
                        last_next     = i_reg[AW-1:0];
                    end
                    i_next     = i_inc;
                    state_next = (i_inc == count_reg) ? S_EMIT_START : S_READ_I;
                end
                else
                begin
                    any_live_next = 1'b1;
                    last_next     = i_reg[AW-1:0];
                    cmd.rd_en     = 1'b1;
                    rd_addr       = i_inc[AW-1:0];
                    j_next        = i_inc;
                    state_next    = S_SCAN_J;
                end
            end
            S_SCAN_J:
            begin
                // The read of the next entry overlaps the test of this one.
                if (status.rd_live && status.touch)
                begin
                    cmd.fold   = 1'b1;
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_KILL;
                    wr_addr    = j_reg[AW-1:0];
                end
                if (j_inc == count_reg)
                begin
                    state_next = S_WRITE_I;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = j_inc[AW-1:0];
                    j_next    = j_inc;
                end
            end
            S_WRITE_I:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_CUR;
                wr_addr    = i_reg[AW-1:0];
                i_next     = i_inc;
                state_next = (i_inc == count_reg) ? S_EMIT_START : S_READ_I;
            end
            S_EMIT_START:
            begin
                if (any_live_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = '0;
                    j_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_EMPTY;
                end
            end
            S_EMIT:
            begin
                if (!status.rd_live)
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = j_inc[AW-1:0];
                    j_next    = j_inc;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (j_reg[AW-1:0] == last_reg);
                    if (j_reg[AW-1:0] == last_reg)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = j_inc[AW-1:0];
                        j_next    = j_inc;
                    end
                end
            end
            S_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = 1'b1;
                    cmd.out_empty = 1'b1;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    state_next    = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            last_reg     <= '0;
            any_live_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            last_reg     <= last_next;
            any_live_reg <= any_live_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("rectangle count beyond store depth");

    // The scan writes one entry while it reads the next, never the same one.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en && cmd.rd_en |-> wr_addr != rd_addr)
        else $error("store read and written at the same entry");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> j_reg[AW-1:0] <= last_reg)
        else $error("emission ran past the last survivor");

    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.out_last |=> count_reg == '0 && !overflow_reg)
        else $error("frame state not cleared after the final word");

endmodule

// ----- hw/rtl/bounding_box_merge_unit.sv -----
// Bounding-box merge unit.
// The rect channel carries one region rectangle per word; the word with
// frame_last set closes the frame. Up to MAX_RECTS rectangles are kept in a
// single-port-read store, further ones are dropped and flag overflow.
// While loading, the unit is always ready. After the closing word it stops
// taking words, runs one greedy merge pass and then sends the surviving
// rectangles on the result channel in arrival order, out_last on the final
// one. A frame with no survivor yields one word with out_empty set.
// The pass costs one store read per pair compare. Emission reads each entry
// up to the last survivor in turn, holding while the result is not taken.
// A result word waits in the output register while ready is low and the
// emission holds; the next frame is taken as soon as the final word is in
// that register. Reset empties the frame and drops any pending result.
module bounding_box_merge_unit
    import bbm_pkg::*;
#(
    parameter int MAX_RECTS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    bbm_rect_if.sink            rect,
    bbm_result_if.source        result
);

    localparam int AW = $clog2(MAX_RECTS);

    dp_cmd_t       cmd;
    dp_status_t    status;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    bbm_controller #(
        .MAX_RECTS (MAX_RECTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rect.valid),
        .in_last  (rect.frame_last),
        .in_ready (rect.ready),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .status   (status)
    );

    bbm_datapath #(
        .MAX_RECTS (MAX_RECTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .status       (status),
        .in_x         (rect.rect_x),
        .in_y         (rect.rect_y),
        .in_width     (rect.rect_width),
        .in_height    (rect.rect_height),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_x        (result.out_x),
        .out_y        (result.out_y),
        .out_width    (result.out_width),
        .out_height   (result.out_height),
        .out_last     (result.out_last),
        .out_empty    (result.out_empty),
        .out_overflow (result.out_overflow)
    );

endmodule
